FILE: design/wpls_pkg.sv
`timescale 1ns / 1ps
package wpls_pkg;

    // defaults for the top-level parameters
    localparam int MOTORS_DEF    = 4;
    localparam int CMD_CLAMP_DEF = 16000;

    // field and register widths
    localparam int COEF_W  = 36;
    localparam int POWER_W = 24;
    localparam int LIMIT_W = 8;
    localparam int CFG_W   = 36;
    localparam int IDX_W   = 3;

    // register reset values
    localparam logic [COEF_W-1:0]  TORQUE_RST   = 36'd684659727;
    localparam logic [COEF_W-1:0]  SPEED_SQ_RST = 36'd34224173;
    localparam logic [COEF_W-1:0]  CMD_SQ_RST   = 36'd44535390;
    localparam logic [POWER_W-1:0] STATIC_RST   = 24'd199790;
    localparam logic [LIMIT_W-1:0] ULIMIT_RST   = 8'd60;

    // floors: 1e-7 in Q.48 and 0.7 W in Q.16
    localparam logic [COEF_W-1:0]  COEF_FLOOR  = 36'd28147498;
    localparam logic [POWER_W-1:0] POWER_FLOOR = 24'd45875;

    // referee limit window and minimum limit in watts
    localparam logic [15:0]        REF_LO    = 16'd15;
    localparam logic [15:0]        REF_HI    = 16'd200;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN = 8'd5;

    // internal arithmetic widths, sized for up to eight motors
    localparam int SUM_W  = 48;            // power sums, watts Q.16
    localparam int DISC_W = 80;            // discriminant
    localparam int RAD_W  = DISC_W + 32;   // discriminant scaled by 2^32
    localparam int ROOT_W = RAD_W / 2;
    localparam int H_W    = 60;            // root-test values and divider
    localparam int Q_W    = 16;            // scale factor fraction bits
    localparam int SCALE_W = Q_W + 1;

    typedef enum logic [IDX_W-1:0] {
        REG_TORQUE     = 3'd0,
        REG_SPEED_SQ   = 3'd1,
        REG_CMD_SQ     = 3'd2,
        REG_STATIC     = 3'd3,
        REG_USER_LIMIT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0]  torque;
        logic [COEF_W-1:0]  speed_sq;
        logic [COEF_W-1:0]  cmd_sq;
        logic [POWER_W-1:0] static_pwr;
        logic [LIMIT_W-1:0] user_limit;
    } cfg_t;

    typedef struct packed {
        logic                    over;
        logic signed [SUM_W-1:0] a0;
        logic signed [SUM_W-1:0] b0;
        logic signed [SUM_W-1:0] c0;
    } sums_t;

endpackage

FILE: design/wpls_terms.sv
`timescale 1ns / 1ps
module wpls_terms import wpls_pkg::*; #(
    parameter int MOTORS = MOTORS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [MOTORS*32+15:0]   in_data,
    input  cfg_t                    cfg,
    output logic                    out_valid,
    output sums_t                   sums,
    output logic [MOTORS*16-1:0]    cmds
);

    localparam int CW = MOTORS * 16;

    logic [5:0] vld_reg;

    // floored coefficients
    logic [COEF_W-1:0]  k2, ac;
    logic [POWER_W-1:0] cp;

    // stage 1: magnitudes and limit
    logic [15:0]        wm1_reg [MOTORS];
    logic [15:0]        tm1_reg [MOTORS];
    logic [MOTORS-1:0]  neg1_reg;
    logic [LIMIT_W-1:0] lim1_reg;
    logic [CW-1:0]      cmd1_reg;

    // stage 2: squares and cross products
    logic [31:0]        sqw2_reg [MOTORS];
    logic [31:0]        sqt2_reg [MOTORS];
    logic [31:0]        wt2_reg  [MOTORS];
    logic [MOTORS-1:0]  neg2_reg;
    logic [LIMIT_W-1:0] lim2_reg;
    logic [CW-1:0]      cmd2_reg;

    // stage 3: coefficient partial products
    logic [49:0]        alo3_reg [MOTORS];
    logic [49:0]        ahi3_reg [MOTORS];
    logic [49:0]        klo3_reg [MOTORS];
    logic [49:0]        khi3_reg [MOTORS];
    logic [49:0]        blo3_reg [MOTORS];
    logic [49:0]        bhi3_reg [MOTORS];
    logic [MOTORS-1:0]  neg3_reg;
    logic [LIMIT_W-1:0] lim3_reg;
    logic [CW-1:0]      cmd3_reg;

    // stage 4: per-motor terms in watts Q.16
    logic [35:0]        at4_reg [MOTORS];
    logic [35:0]        kt4_reg [MOTORS];
    logic [35:0]        bt4_reg [MOTORS];
    logic [MOTORS-1:0]  neg4_reg;
    logic [LIMIT_W-1:0] lim4_reg;
    logic [CW-1:0]      cmd4_reg;

    // stage 5: sums
    logic signed [SUM_W-1:0] a5_reg, b5_reg, c5_reg;
    logic [CW-1:0]           cmd5_reg;

    // stage 6: over-limit decision
    sums_t         sums_reg;
    logic [CW-1:0] cmd6_reg;

    logic signed [SUM_W-1:0] a_sum, b_sum, k_sum, c_next;
    logic [LIMIT_W-1:0]      lim_next;
    logic [15:0]             ref_lim;

    assign k2 = (cfg.speed_sq < COEF_FLOOR) ? COEF_FLOOR : cfg.speed_sq;
    assign ac = (cfg.cmd_sq < COEF_FLOOR) ? COEF_FLOOR : cfg.cmd_sq;
    assign cp = (cfg.static_pwr < POWER_FLOOR) ? POWER_FLOOR : cfg.static_pwr;

    // limit selection
    always_comb begin
        ref_lim = in_data[MOTORS*32 +: 16];
        if (ref_lim >= REF_LO && ref_lim <= REF_HI) begin
            lim_next = ref_lim[LIMIT_W-1:0];
        end else begin
            lim_next = cfg.user_limit;
        end
        if (lim_next < LIMIT_MIN) begin
            lim_next = LIMIT_MIN;
        end
    end

    // sums over the motors
    always_comb begin
        a_sum = '0;
        b_sum = '0;
        k_sum = '0;
        for (int i = 0; i < MOTORS; i++) begin
            a_sum = a_sum + SUM_W'(at4_reg[i]);
            k_sum = k_sum + SUM_W'(kt4_reg[i]);
            if (neg4_reg[i]) begin
                b_sum = b_sum - SUM_W'(bt4_reg[i]);
            end else begin
                b_sum = b_sum + SUM_W'(bt4_reg[i]);
            end
        end
        c_next = k_sum + SUM_W'(cp) * SUM_W'(MOTORS) - SUM_W'({lim4_reg, 16'd0});
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < MOTORS; i++) begin
                logic [15:0] w, t;
                w = in_data[i*16 +: 16];
                t = in_data[(MOTORS+i)*16 +: 16];
                wm1_reg[i]  <= w[15] ? 16'(-w) : w;
                tm1_reg[i]  <= t[15] ? 16'(-t) : t;
                neg1_reg[i] <= w[15] ^ t[15];

                sqw2_reg[i] <= wm1_reg[i] * wm1_reg[i];
                sqt2_reg[i] <= tm1_reg[i] * tm1_reg[i];
                wt2_reg[i]  <= wm1_reg[i] * tm1_reg[i];

                alo3_reg[i] <= ac[17:0] * sqt2_reg[i];
                ahi3_reg[i] <= ac[35:18] * sqt2_reg[i];
                klo3_reg[i] <= k2[17:0] * sqw2_reg[i];
                khi3_reg[i] <= k2[35:18] * sqw2_reg[i];
                blo3_reg[i] <= cfg.torque[17:0] * wt2_reg[i];
                bhi3_reg[i] <= cfg.torque[35:18] * wt2_reg[i];
            end
            for (int i = 0; i < MOTORS; i++) begin
                logic [67:0] fa, fk, fb;
                fa = {ahi3_reg[i], 18'd0} + 68'(alo3_reg[i]);
                fk = {khi3_reg[i], 18'd0} + 68'(klo3_reg[i]);
                fb = {bhi3_reg[i], 18'd0} + 68'(blo3_reg[i]);
                at4_reg[i] <= fa[67:32];
                kt4_reg[i] <= fk[67:32];
                bt4_reg[i] <= fb[67:32];
            end
            neg2_reg <= neg1_reg;
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            lim1_reg <= lim_next;
            lim2_reg <= lim1_reg;
            lim3_reg <= lim2_reg;
            lim4_reg <= lim3_reg;
            cmd1_reg <= in_data[CW +: CW];
            cmd2_reg <= cmd1_reg;
            cmd3_reg <= cmd2_reg;
            cmd4_reg <= cmd3_reg;
            cmd5_reg <= cmd4_reg;
            cmd6_reg <= cmd5_reg;
            a5_reg   <= a_sum;
            b5_reg   <= b_sum;
            c5_reg   <= c_next;
            sums_reg.a0   <= a5_reg;
            sums_reg.b0   <= b5_reg;
            sums_reg.c0   <= c5_reg;
            sums_reg.over <= (a5_reg + b5_reg + c5_reg) > 0;
        end
    end

    assign out_valid = vld_reg[5];
    assign sums      = sums_reg;
    assign cmds      = cmd6_reg;

endmodule

FILE: design/wpls_isqrt.sv
`timescale 1ns / 1ps
module wpls_isqrt import wpls_pkg::*; #(
    parameter int RADIX_W = RAD_W,
    parameter int SIDE_W  = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [RADIX_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [RADIX_W/2-1:0]   root,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int N   = RADIX_W / 2;
    localparam int RMW = N + 2;

    logic [N-1:0]       vld_reg;
    logic [RMW-1:0]     rem_reg  [1:N];
    logic [N-1:0]       root_reg [1:N];
    logic [RADIX_W-1:0] x_reg    [1:N];
    logic [SIDE_W-1:0]  side_reg [1:N];

    // one result bit: remainder and root after taking two radicand bits
    function automatic logic [RMW+N-1:0] sq_step(input logic [RMW-1:0] rem,
                                                 input logic [N-1:0]   rt,
                                                 input logic [1:0]     bits);
        logic [RMW+1:0] cat;
        logic [RMW+1:0] trial;
        cat   = {rem, bits};
        trial = (RMW+2)'({rt, 2'b01});
        if (cat >= trial) begin
            return {RMW'(cat - trial), rt[N-2:0], 1'b1};
        end else begin
            return {cat[RMW-1:0], rt[N-2:0], 1'b0};
        end
    endfunction

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // digit recurrence, one root bit per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            {rem_reg[1], root_reg[1]} <= sq_step('0, '0, radicand[RADIX_W-1 -: 2]);
            x_reg[1]    <= radicand << 2;
            side_reg[1] <= in_side;
            for (int k = 1; k < N; k++) begin
                {rem_reg[k+1], root_reg[k+1]} <=
                    sq_step(rem_reg[k], root_reg[k], x_reg[k][RADIX_W-1 -: 2]);
                x_reg[k+1]    <= x_reg[k] << 2;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

FILE: design/wpls_root.sv
`timescale 1ns / 1ps
module wpls_root import wpls_pkg::*; #(
    parameter int MOTORS = MOTORS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  sums_t                 sums,
    input  logic [MOTORS*16-1:0]  in_cmds,
    output logic                  out_valid,
    output logic                  over,
    output logic                  zero,
    output logic [Q_W-1:0]        quot,
    output logic [MOTORS*16-1:0]  out_cmds
);

    localparam int CW     = MOTORS * 16;
    localparam int SIDE_W = 2 + 2 * SUM_W + CW;

    // stage 1: magnitudes and partial products
    logic [2:0]              vld_reg;
    logic [56:0]             bblo1_reg, bbhi1_reg;
    logic [58:0]             aclo1_reg, achi1_reg;
    logic                    cneg1_reg;
    sums_t                   s1_reg, s2_reg;
    logic [CW-1:0]           cmd1_reg, cmd2_reg, cmd3_reg;
    // stage 2: squared b and 4ac
    logic [DISC_W-1:0]       b2_2_reg, ac2_reg;
    logic                    cneg2_reg;
    // stage 3: discriminant
    logic [DISC_W-1:0]       d3_reg;
    logic                    over3_reg, zero3_reg;
    logic signed [SUM_W-1:0] a3_reg, b3_reg;

    logic [37:0]             bm;
    logic [39:0]             cm;
    logic [38:0]             a4;
    logic [DISC_W-1:0]       d_next;
    logic                    d_neg;

    // square root
    logic                    sq_valid;
    logic [ROOT_W-1:0]       sq_root;
    logic [SIDE_W-1:0]       sq_side;

    // solve and divide stages: index 0 is the root test
    logic [Q_W:0]            dv_vld_reg;
    logic [H_W-1:0]          n_reg    [0:Q_W];
    logic [H_W-1:0]          dv_reg   [0:Q_W];
    logic [Q_W-1:0]          q_reg    [0:Q_W];
    logic                    ov_reg   [0:Q_W];
    logic                    zr_reg   [0:Q_W];
    logic [CW-1:0]           dcmd_reg [0:Q_W];

    logic                    sq_over, sq_zero;
    logic signed [SUM_W-1:0] sq_a0, sq_b0;
    logic [CW-1:0]           sq_cmds;
    logic signed [H_W-1:0]   h0, h1, rs;
    logic                    zero_s;

    assign bm = sums.b0[SUM_W-1] ? 38'(-sums.b0) : 38'(sums.b0);
    assign cm = (sums.c0 <= 0) ? 40'(-sums.c0) : 40'(sums.c0);
    assign a4 = {sums.a0[36:0], 2'b00};

    always_comb begin
        if (cneg2_reg) begin
            d_next = b2_2_reg + ac2_reg;
            d_neg  = 1'b0;
        end else begin
            d_next = b2_2_reg - ac2_reg;
            d_neg  = b2_2_reg < ac2_reg;
        end
    end

    // root test against both ends of the unit interval
    always_comb begin
        {sq_over, sq_zero, sq_a0, sq_b0, sq_cmds} = sq_side;
        h0     = H_W'(sq_b0) <<< Q_W;
        h1     = h0 + (H_W'(sq_a0) <<< (Q_W + 1));
        rs     = signed'(H_W'(sq_root));
        zero_s = sq_zero || (h0 > rs) || (h1 <= rs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            dv_vld_reg <= '0;
        end else if (en) begin
            vld_reg    <= {vld_reg[1:0], in_valid};
            dv_vld_reg <= {dv_vld_reg[Q_W-1:0], sq_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // discriminant partial products
            bblo1_reg <= bm * bm[18:0];
            bbhi1_reg <= bm * bm[37:19];
            aclo1_reg <= a4 * cm[19:0];
            achi1_reg <= a4 * cm[39:20];
            cneg1_reg <= sums.c0 <= 0;
            s1_reg    <= sums;
            cmd1_reg  <= in_cmds;

            b2_2_reg  <= {4'd0, bbhi1_reg, 19'd0} + DISC_W'(bblo1_reg);
            ac2_reg   <= {1'b0, achi1_reg, 20'd0} + DISC_W'(aclo1_reg);
            cneg2_reg <= cneg1_reg;
            s2_reg    <= s1_reg;
            cmd2_reg  <= cmd1_reg;

            d3_reg    <= d_neg ? '0 : d_next;
            zero3_reg <= d_neg || (s2_reg.a0 == 0);
            over3_reg <= s2_reg.over;
            a3_reg    <= s2_reg.a0;
            b3_reg    <= s2_reg.b0;
            cmd3_reg  <= cmd2_reg;

            // numerator for the scale division
            n_reg[0]    <= zero_s ? '0 : H_W'(rs - h0);
            dv_reg[0]   <= H_W'(sq_a0) << 1;
            q_reg[0]    <= '0;
            ov_reg[0]   <= sq_over;
            zr_reg[0]   <= zero_s;
            dcmd_reg[0] <= sq_cmds;

            // restoring division, one quotient bit per stage, msb first
            for (int k = 0; k < Q_W; k++) begin
                logic [H_W-1:0] trial;
                logic [Q_W-1:0] qn;
                trial = dv_reg[k] << (Q_W - 1 - k);
                qn    = q_reg[k];
                if (n_reg[k] >= trial) begin
                    n_reg[k+1]      <= n_reg[k] - trial;
                    qn[Q_W-1-k] = 1'b1;
                end else begin
                    n_reg[k+1] <= n_reg[k];
                end
                q_reg[k+1]    <= qn;
                dv_reg[k+1]   <= dv_reg[k];
                ov_reg[k+1]   <= ov_reg[k];
                zr_reg[k+1]   <= zr_reg[k];
                dcmd_reg[k+1] <= dcmd_reg[k];
            end
        end
    end

    wpls_isqrt #(
        .RADIX_W (RAD_W),
        .SIDE_W  (SIDE_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[2]),
        .radicand  ({d3_reg, 32'd0}),
        .in_side   ({over3_reg, zero3_reg, a3_reg, b3_reg, cmd3_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    assign out_valid = dv_vld_reg[Q_W];
    assign over      = ov_reg[Q_W];
    assign zero      = zr_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign out_cmds  = dcmd_reg[Q_W];

endmodule

FILE: design/wheel_power_limit_scaler.sv
`timescale 1ns / 1ps
// Wheel power limiter for MOTORS motors. Each transaction carries all motor speeds,
// current commands and the referee power limit; the block predicts total power
// from the quadratic motor model and, when it exceeds the limit, scales every
// command by the largest root in [0,1] of the power equation, then clamps to
// +-CMD_CLAMP. A new transaction is accepted every cycle while the output register
// is free or being read. The 56-stage square root and 16-stage divider find the
// scale factor. The user writes coefficient registers on the cfg port only while
// no transaction is in flight (not enforced by the block); they take effect at once.
module wheel_power_limit_scaler import wpls_pkg::*; #(
    parameter int MOTORS    = MOTORS_DEF,
    parameter int CMD_CLAMP = CMD_CLAMP_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // speed_0.. , cmd_0.. , referee_limit
    input  logic [MOTORS*32+15:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // out_0.. , was_scaled, scale_factor, zero fill
    output logic [((MOTORS*15+1+SCALE_W+7)/8)*8-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int CW    = MOTORS * 16;
    localparam int OUT_W = ((MOTORS * 15 + 1 + SCALE_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - MOTORS * 15 - 1 - SCALE_W;
    localparam logic signed [17:0] CLAMP = 18'(CMD_CLAMP);
    localparam logic [SCALE_W-1:0] ONE   = SCALE_W'(1) << Q_W;

    cfg_t                cfg_reg;
    logic                en;
    logic                t_valid, r_valid, r_over, r_zero;
    sums_t               t_sums;
    logic [CW-1:0]       t_cmds, r_cmds;
    logic [Q_W-1:0]      r_quot;

    logic                a_vld_reg;
    logic [32:0]         prod_reg [MOTORS];
    logic [CW-1:0]       a_cmd_reg;
    logic                a_over_reg;
    logic [SCALE_W-1:0]  a_scale_reg;
    logic [SCALE_W-1:0]  scale_next;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [MOTORS*15-1:0] lim_cmds;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.torque     <= TORQUE_RST;
            cfg_reg.speed_sq   <= SPEED_SQ_RST;
            cfg_reg.cmd_sq     <= CMD_SQ_RST;
            cfg_reg.static_pwr <= STATIC_RST;
            cfg_reg.user_limit <= ULIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_TORQUE:     cfg_reg.torque     <= cfg_data;
                REG_SPEED_SQ:   cfg_reg.speed_sq   <= cfg_data;
                REG_CMD_SQ:     cfg_reg.cmd_sq     <= cfg_data;
                REG_STATIC:     cfg_reg.static_pwr <= cfg_data[POWER_W-1:0];
                REG_USER_LIMIT: cfg_reg.user_limit <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register is free
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    wpls_terms #(
        .MOTORS (MOTORS)
    ) u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .cfg       (cfg_reg),
        .out_valid (t_valid),
        .sums      (t_sums),
        .cmds      (t_cmds)
    );

    wpls_root #(
        .MOTORS (MOTORS)
    ) u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_valid),
        .sums      (t_sums),
        .in_cmds   (t_cmds),
        .out_valid (r_valid),
        .over      (r_over),
        .zero      (r_zero),
        .quot      (r_quot),
        .out_cmds  (r_cmds)
    );

    // applied scale
    always_comb begin
        if (!r_over) begin
            scale_next = ONE;
        end else if (r_zero) begin
            scale_next = '0;
        end else begin
            scale_next = SCALE_W'(r_quot);
        end
    end

    // output clamp
    always_comb begin
        for (int i = 0; i < MOTORS; i++) begin
            logic signed [17:0] v;
            logic [15:0]        t;
            logic [16:0]        mag;
            t   = a_cmd_reg[i*16 +: 16];
            mag = prod_reg[i][32:16];
            if (a_over_reg) begin
                v = t[15] ? -signed'(18'(mag)) : signed'(18'(mag));
            end else begin
                v = 18'(signed'(t));
            end
            if (v > CLAMP) begin
                v = CLAMP;
            end else if (v < -CLAMP) begin
                v = -CLAMP;
            end
            lim_cmds[i*15 +: 15] = v[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg    <= r_valid;
            m_tvalid_reg <= a_vld_reg;
        end
    end

    // scale multiply, then clamp into the output register
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < MOTORS; i++) begin
                logic [15:0] t;
                t = r_cmds[i*16 +: 16];
                prod_reg[i] <= (t[15] ? 16'(-t) : t) * scale_next;
            end
            a_cmd_reg   <= r_cmds;
            a_over_reg  <= r_over;
            a_scale_reg <= scale_next;
            m_tdata_reg <= {{PAD_W{1'b0}}, a_scale_reg, a_over_reg, lim_cmds};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: dv/wheel_power_limit_scaler_test.sv
`timescale 1ns / 1ps
module wheel_power_limit_scaler_test;
    import wpls_pkg::*;

    localparam int NMOT = 4;
    localparam int CLAMP = 16000;
    localparam int IN_W = NMOT * 32 + 16;
    localparam int OUT_W = ((NMOT * 15 + 1 + SCALE_W + 7) / 8) * 8;
    localparam int LATENCY = 84;

    // one four-motor command set
    typedef struct {
        logic signed [15:0] speed [NMOT];
        logic signed [15:0] cmd [NMOT];
        logic [15:0]        ref_limit;
    } motor_set_t;

    // one limited command set
    typedef struct {
        logic signed [14:0] lim [NMOT];
        logic               scaled;
        logic [16:0]        scale;
    } limited_t;

    logic aclk;
    logic aresetn;
    logic [IN_W-1:0] s_tdata;
    logic s_tvalid;
    logic s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // local copy of the coefficient registers
    logic [35:0] tc_q, k2_q, a_q;
    logic [23:0] pwr_q;
    logic [7:0]  ulim_q;

    limited_t expected_q[$];
    int errors = 0;
    int n_results = 0;
    int n_scaled = 0;
    int n_zero = 0;
    bit idle_en = 1'b1;

    wheel_power_limit_scaler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // coefficient (Q.48) times magnitude, down to Q.16
    function automatic logic [63:0] to_watts(logic [35:0] coef, logic [31:0] m);
        logic [67:0] p;
        p = 68'(coef) * 68'(m);
        return 64'(p >> 32);
    endfunction

    // is k/65536 at or below the largest root
    function automatic bit root_above(longint a0, longint b0, logic [127:0] dsh,
                                      longint k);
        longint h;
        logic [127:0] hh;
        h = 2 * a0 * k + b0 * 65536;
        if (h <= 0) return 1'b1;
        hh = 128'(h) * 128'(h);
        return !(dsh < hh);
    endfunction

    function automatic longint find_scale(longint a0, longint b0, longint c0);
        logic [127:0] d, t, dsh;
        longint lo, hi, mid, bm;
        lo = 0;
        hi = 65536;
        bm = b0 < 0 ? -b0 : b0;
        if (a0 <= 0) return 0;
        d = 128'(bm) * 128'(bm);
        if (c0 <= 0) begin
            d = d + 128'(4 * a0) * 128'(-c0);
        end else begin
            t = 128'(4 * a0) * 128'(c0);
            if (d < t) return 0;
            d = d - t;
        end
        dsh = d << 32;
        if (!root_above(a0, b0, dsh, 0) || root_above(a0, b0, dsh, 65536)) return 0;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (root_above(a0, b0, dsh, mid)) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // expected limited commands for one set
    function automatic limited_t limit_power(motor_set_t s);
        limited_t r;
        logic [35:0] k2, a;
        logic [23:0] c;
        longint lim, a0, b0, ksum, c0, total, scale, v, mag, wm, tm, bt;
        bit over;
        k2 = k2_q > COEF_FLOOR ? k2_q : COEF_FLOOR;
        a = a_q > COEF_FLOOR ? a_q : COEF_FLOOR;
        c = pwr_q > POWER_FLOOR ? pwr_q : POWER_FLOOR;
        lim = (s.ref_limit >= REF_LO && s.ref_limit <= REF_HI) ? s.ref_limit : ulim_q;
        if (lim < LIMIT_MIN) lim = LIMIT_MIN;
        a0 = 0; b0 = 0; ksum = 0;
        for (int i = 0; i < NMOT; i++) begin
            wm = s.speed[i] < 0 ? -longint'(s.speed[i]) : longint'(s.speed[i]);
            tm = s.cmd[i] < 0 ? -longint'(s.cmd[i]) : longint'(s.cmd[i]);
            a0 += longint'(to_watts(a, 32'(tm * tm)));
            ksum += longint'(to_watts(k2, 32'(wm * wm)));
            bt = longint'(to_watts(tc_q, 32'(wm * tm)));
            if ((s.speed[i] < 0) != (s.cmd[i] < 0)) b0 -= bt;
            else b0 += bt;
        end
        c0 = ksum + NMOT * longint'(c) - (lim << 16);
        total = a0 + b0 + c0;
        over = total > 0;
        scale = over ? find_scale(a0, b0, c0) : 65536;
        for (int i = 0; i < NMOT; i++) begin
            v = s.cmd[i];
            if (over) begin
                mag = (v < 0 ? -v : v) * scale / 65536;
                v = v < 0 ? -mag : mag;
            end
            if (v > CLAMP) v = CLAMP;
            if (v < -CLAMP) v = -CLAMP;
            r.lim[i] = 15'(v);
        end
        r.scaled = over;
        r.scale = 17'(scale);
        return r;
    endfunction

    // register write, only while idle
    task automatic write_reg(cfg_reg_t idx, logic [35:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TORQUE:     tc_q = val;
            REG_SPEED_SQ:   k2_q = val;
            REG_CMD_SQ:     a_q = val;
            REG_STATIC:     pwr_q = val[23:0];
            REG_USER_LIMIT: ulim_q = val[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // send one transaction and queue its expectation
    task automatic send_set(motor_set_t s);
        logic [IN_W-1:0] d;
        for (int i = 0; i < NMOT; i++) begin
            d[i*16 +: 16] = s.speed[i];
            d[(NMOT+i)*16 +: 16] = s.cmd[i];
        end
        d[NMOT*32 +: 16] = s.ref_limit;
        while (idle_en && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(limit_power(s));
    endtask

    function automatic motor_set_t rand_set(int mode);
        motor_set_t s;
        for (int i = 0; i < NMOT; i++) begin
            case (mode)
                0: begin
                    s.speed[i] = 16'($urandom);
                    s.cmd[i] = 16'($urandom);
                end
                1: begin
                    s.speed[i] = 16'($urandom_range(16000) - 8000);
                    s.cmd[i] = 16'($urandom_range(32000) - 16000);
                end
                default: begin
                    s.speed[i] = 16'($urandom_range(2000) - 1000);
                    s.cmd[i] = 16'($urandom_range(6000) - 3000);
                end
            endcase
        end
        case ($urandom_range(3))
            0: s.ref_limit = 16'($urandom);
            1: s.ref_limit = 16'($urandom_range(14));
            default: s.ref_limit = 16'($urandom_range(215, 10));
        endcase
        return s;
    endfunction

    function automatic motor_set_t fill_set(int w, int t, int lim);
        motor_set_t s;
        for (int i = 0; i < NMOT; i++) begin
            s.speed[i] = 16'(w);
            s.cmd[i] = 16'(t);
        end
        s.ref_limit = 16'(lim);
        return s;
    endfunction

    // extremes, limit window edges, under limit, no root, sign mix
    task automatic test_directed;
        motor_set_t s;
        send_set(fill_set(0, 0, 0));
        send_set(fill_set(32767, 32767, 14));
        send_set(fill_set(-32768, -32768, 15));
        send_set(fill_set(-32768, 32767, 200));
        send_set(fill_set(32767, -32768, 201));
        send_set(fill_set(0, 20000, 65535));
        send_set(fill_set(0, -20000, 100));
        send_set(fill_set(100, 200, 200));
        send_set(fill_set(9000, 0, 15));
        send_set(fill_set(5000, -3000, 50));
        send_set(fill_set(-5000, 3000, 80));
        send_set(fill_set(3000, 3000, 40));
        s = fill_set(1, 1, 16'hFFFF);
        s.speed[0] = 16'sh5555; s.cmd[1] = 16'shAAAA; s.speed[2] = -16'sd1;
        send_set(s);
        drain();
    endtask

    // random sets under the current register values
    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_set(rand_set($urandom_range(2)));
        drain();
    endtask

    task automatic test_registers;
        write_reg(REG_TORQUE, 36'd0);
        write_reg(REG_SPEED_SQ, 36'd0);
        write_reg(REG_CMD_SQ, 36'd0);
        write_reg(REG_STATIC, 36'd0);
        write_reg(REG_USER_LIMIT, 36'd0);
        test_random(120);
        write_reg(REG_TORQUE, 36'hF_FFFF_FFFF);
        write_reg(REG_SPEED_SQ, 36'hF_FFFF_FFFF);
        write_reg(REG_CMD_SQ, 36'hF_FFFF_FFFF);
        write_reg(REG_STATIC, 36'hFF_FFFF);
        write_reg(REG_USER_LIMIT, 36'd255);
        test_random(100);
        write_reg(REG_TORQUE, 36'd2000000000);
        write_reg(REG_SPEED_SQ, 36'd28147499);
        write_reg(REG_CMD_SQ, 36'd80000000);
        write_reg(REG_STATIC, 36'd45875);
        write_reg(REG_USER_LIMIT, 36'd5);
        test_random(120);
        write_reg(REG_TORQUE, 36'(longint'($urandom) * 8));
        write_reg(REG_SPEED_SQ, 36'($urandom));
        write_reg(REG_CMD_SQ, 36'($urandom));
        write_reg(REG_STATIC, 36'($urandom_range(2000000)));
        write_reg(REG_USER_LIMIT, 36'($urandom_range(200, 5)));
        test_random(100);
    endtask

    // result side stall
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !idle_en || ($urandom_range(99) >= 22);
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        limited_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, m_tdata);
                errors++;
            end else begin
                e = expected_q.pop_front();
                n_results++;
                if (e.scaled) n_scaled++;
                if (e.scaled && e.scale == 0) n_zero++;
                for (int i = 0; i < NMOT; i++)
                    if (m_tdata[i*15 +: 15] !== e.lim[i]) begin
                        $display("%0t: out_%0d expected %0d actual %0d", $time, i,
                                 e.lim[i], $signed(m_tdata[i*15 +: 15]));
                        errors++;
                    end
                if (m_tdata[NMOT*15] !== e.scaled) begin
                    $display("%0t: was_scaled expected %0d actual %0d", $time,
                             e.scaled, m_tdata[NMOT*15]);
                    errors++;
                end
                if (m_tdata[NMOT*15+1 +: 17] !== e.scale) begin
                    $display("%0t: scale_factor expected %0d actual %0d", $time,
                             e.scale, m_tdata[NMOT*15+1 +: 17]);
                    errors++;
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_TORQUE;
        cfg_data <= '0;
        tc_q = TORQUE_RST; k2_q = SPEED_SQ_RST; a_q = CMD_SQ_RST;
        pwr_q = STATIC_RST; ulim_q = ULIMIT_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(150);
        idle_en = 1'b0;
        test_random(150);
        idle_en = 1'b1;
        test_registers();
        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            errors++;
        end
        $display("checked %0d command sets: %0d over the limit, %0d with no root",
                 n_results, n_scaled, n_zero);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
